// ----- rtl/core/rv32im_execute_core_macros.svh -----
// ----------------------------------------------------------------------------
// RV32IM execute core assertion macros
// Shared concurrent assertion helpers for the execute core.
// ----------------------------------------------------------------------------
`ifndef RV32IM_EXECUTE_CORE_MACROS_SVH
`define RV32IM_EXECUTE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RVX_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define RVX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RVX_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RVX_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/core/rvx_pkg.sv -----
// ----------------------------------------------------------------------------
// RV32IM execute core package
// Shared widths, codes and types of the execute core.
// ----------------------------------------------------------------------------
package rvx_pkg;
   localparam int REG_COUNT = 32;
   localparam int REG_IDX_W = $clog2(REG_COUNT);
   localparam logic [31:0] RESET_VECTOR_DEFAULT = 32'h8000_0000;
   localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_JAL    = 7'h6f;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_SYSTEM = 7'h73;
   localparam logic [6:0] OP_IMM32  = 7'h1b;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_EBREAK  = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_SEQ     = 3'd3;
   localparam logic [2:0] ST_HALTED  = 3'd4;

   typedef struct packed {
      logic       cmd;
      logic [31:0] word;
      logic [31:0] load_value;
   } req_item_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  mem_kind;
      logic [31:0] mem_address;
      logic [1:0]  mem_size_code;
      logic [31:0] store_value;
      logic        dest_write;
      logic [4:0]  dest_reg;
      logic [31:0] dest_value;
      logic [2:0]  status;
      logic [31:0] status_value;
   } rsp_item_type;
endpackage

// ----- rtl/core/rvx_front.sv -----
// ----------------------------------------------------------------------------
// RV32IM execute core front end
// Accepts items and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rvx_front import rvx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         q_valid,
   input  logic         q_ready,
   output req_item_type q_item
);
   req_item_type mem_ff [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = mem_ff[rp_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= in_item;
      end
   end
endmodule

// ----- rtl/core/rvx_divider.sv -----
// ----------------------------------------------------------------------------
// RV32IM execute core divider
// Radix-2 restoring divider for unsigned magnitudes, one bit per cycle.
// ----------------------------------------------------------------------------
module rvx_divider import rvx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [31:0] q_ff, q_in, r_ff, r_in, d_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   assign trial     = {r_ff, q_ff[31]} - {1'b0, d_ff};
   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = dividend;
         r_in = 32'd0;
         cnt_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[32]) begin
            r_in = {r_ff[30:0], q_ff[31]};
            q_in = {q_ff[30:0], 1'b0};
         end else begin
            r_in = trial[31:0];
            q_in = {q_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) begin
         d_ff <= divisor;
      end
   end
endmodule

// ----- rtl/core/rvx_back.sv -----
// ----------------------------------------------------------------------------
// RV32IM execute core back end
// Decodes and executes queued items against the pc and register file.
// ----------------------------------------------------------------------------
module rvx_back import rvx_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata,
   input  logic         q_valid,
   output logic         q_ready,
   input  req_item_type q_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);
   typedef enum logic [1:0] {S_RUN, S_MUL, S_DIV, S_DIVWAIT} state_type;

   state_type    state_ff, state_in;
   logic [31:0]  pc_ff, pc_in;
   logic [31:0]  rf_ff [REG_COUNT];
   logic [REG_COUNT-1:0] rf_vld_ff;
   logic         lw_ff, lw_in, halt_ff, halt_in;
   logic [4:0]   ld_ff, ld_in;
   logic [2:0]   lf_ff, lf_in;
   logic         ov_ff, ov_in;
   rsp_item_type ob_ff, ob_in;

   logic [31:0]  w, a, b, immI, immS, immB, immJ, val, npc, ra10;
   logic [6:0]   opc, f7;
   logic [2:0]   f3;
   logic [4:0]   rd;
   logic         valid, wr, take, lts, go, is_mul, is_div;
   rsp_item_type r;

   logic [63:0]  prod_ff;
   logic signed [63:0] prod_in;
   logic [2:0]   mf3_ff;
   logic [4:0]   mrd_ff;
   logic [31:0]  mpc_ff, da_ff, db_ff;
   logic         na_ff, nb_ff;
   logic         dstart, ddone;
   logic [31:0]  dq, dr, mres, dres, qs, rs;

   logic         rf_we, cap;
   logic [4:0]   rf_wa;
   logic [31:0]  rf_wd, ldv, xres;

   function automatic logic [31:0] rd_reg(input logic [4:0] idx,
         input logic [REG_COUNT-1:0] v, input logic [31:0] x);
      logic [31:0] res;
      res = 32'd0;
      if (idx != 5'd0 && {27'd0, idx} < REG_COUNT && v[idx[REG_IDX_W-1:0]]) begin
         res = x;
      end
      return res;
   endfunction

   assign w   = q_item.word;
   assign opc = w[6:0];
   assign rd  = w[11:7];
   assign f3  = w[14:12];
   assign f7  = w[31:25];
   assign a   = rd_reg(w[19:15], rf_vld_ff, rf_ff[w[15+REG_IDX_W-1:15]]);
   assign b   = rd_reg(w[24:20], rf_vld_ff, rf_ff[w[20+REG_IDX_W-1:20]]);
   assign ra10 = rd_reg(5'd10, rf_vld_ff, rf_ff[10]);
   assign immI = {{20{w[31]}}, w[31:20]};
   assign immS = {{20{w[31]}}, w[31:25], w[11:7]};
   assign immB = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
   assign immJ = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
   assign lts  = $signed(a) < $signed(b);
   assign prod_in = $signed(a) * $signed(b);

   assign q_ready   = (state_ff == S_RUN) && (!ov_ff || out_ready);
   assign go        = q_valid && q_ready;
   assign out_valid = ov_ff;
   assign out_item  = ob_ff;

   always_comb begin
      r = '0;
      r.next_pc = pc_ff;
      val = 32'd0;
      npc = pc_ff + 32'd4;
      valid = 1'b1;
      wr = 1'b0;
      take = 1'b0;
      is_mul = 1'b0;
      is_div = 1'b0;
      unique case (opc)
         OP_LUI: begin val = {w[31:12], 12'd0}; wr = 1'b1; end
         OP_AUIPC: begin val = pc_ff + {w[31:12], 12'd0}; wr = 1'b1; end
         OP_JAL: begin npc = pc_ff + immJ; val = pc_ff + 32'd4; wr = 1'b1; end
         OP_JALR: begin
            if (f3 != 3'd0) valid = 1'b0;
            npc = (a + immI) & ~32'd1;
            val = pc_ff + 32'd4;
            wr = 1'b1;
         end
         OP_BRANCH: begin
            unique case (f3)
               3'd0: take = (a == b);
               3'd1: take = (a != b);
               3'd4: take = lts;
               3'd5: take = !lts;
               3'd6: take = (a < b);
               3'd7: take = (a >= b);
               default: valid = 1'b0;
            endcase
            if (take) npc = pc_ff + immB;
         end
         OP_LOAD: begin
            if (f3 == 3'd3 || f3 >= 3'd6) valid = 1'b0;
            r.mem_kind = MEM_READ;
            r.mem_address = a + immI;
            r.mem_size_code = f3[1:0];
         end
         OP_STORE: begin
            if (f3 > 3'd2) valid = 1'b0;
            r.mem_kind = MEM_WRITE;
            r.mem_address = a + immS;
            r.mem_size_code = f3[1:0];
            r.store_value = b;
         end
         OP_IMM: begin
            wr = 1'b1;
            unique case (f3)
               3'd0: val = a + immI;
               3'd1: begin
                  if (f7 != 7'd0) valid = 1'b0;
                  val = a << w[24:20];
               end
               3'd3: val = {31'd0, a < immI};
               3'd4: val = a ^ immI;
               3'd5: begin
                  if (f7 == 7'd0) val = a >> w[24:20];
                  else if (f7 == 7'h20) val = 32'($signed(a) >>> w[24:20]);
                  else valid = 1'b0;
               end
               3'd7: val = a & immI;
               default: valid = 1'b0;
            endcase
         end
         OP_REG: begin
            wr = 1'b1;
            if (f7 == 7'd0) begin
               unique case (f3)
                  3'd0: val = a + b;
                  3'd1: val = a << b[4:0];
                  3'd2: val = {31'd0, lts};
                  3'd3: val = {31'd0, a < b};
                  3'd4: val = a ^ b;
                  3'd5: val = a >> b[4:0];
                  3'd6: val = a | b;
                  default: val = a & b;
               endcase
            end else if (f7 == 7'h20 && f3 == 3'd0) begin
               val = a - b;
            end else if (f7 == 7'h20 && f3 == 3'd5) begin
               val = 32'($signed(a) >>> b[4:0]);
            end else if (f7 == 7'd1) begin
               if (f3 == 3'd0 || f3 == 3'd1) is_mul = 1'b1;
               else if (f3 >= 3'd4) is_div = 1'b1;
               else valid = 1'b0;
            end else begin
               valid = 1'b0;
            end
         end
         default: valid = 1'b0;
      endcase
      if (wr && rd != 5'd0 && {27'd0, rd} < REG_COUNT) begin
         r.dest_write = 1'b1;
         r.dest_reg = rd;
         r.dest_value = val;
      end
      r.next_pc = npc;
      if (!valid) begin
         r = '0;
         r.next_pc = pc_ff;
         r.status = ST_INVALID;
         r.status_value = pc_ff;
      end
   end

   rvx_divider u_div (
      .clock(clock), .reset(reset), .start(dstart),
      .dividend(da_ff), .divisor(db_ff),
      .done(ddone), .quotient(dq), .remainder(dr)
   );
   assign dstart = (state_ff == S_DIV);

   always_comb begin
      unique case (mf3_ff[0])
         1'b0: mres = prod_ff[31:0];
         default: mres = prod_ff[63:32];
      endcase
      qs = (na_ff != nb_ff) ? (32'd0 - dq) : dq;
      rs = na_ff ? (32'd0 - dr) : dr;
      if (db_ff == 32'd0) begin
         dres = mf3_ff[1] ? (mf3_ff[2] & mf3_ff[0] ? da_ff : (na_ff ? 32'd0 - da_ff : da_ff))
                          : 32'hFFFF_FFFF;
      end else if (mf3_ff[1]) begin
         dres = rs;
      end else begin
         dres = qs;
      end
      xres = (state_ff == S_MUL) ? mres : dres;
   end

   always_comb begin
      unique case (lf_ff)
         3'd0: ldv = {{24{q_item.load_value[7]}}, q_item.load_value[7:0]};
         3'd1: ldv = {{16{q_item.load_value[15]}}, q_item.load_value[15:0]};
         3'd4: ldv = {24'd0, q_item.load_value[7:0]};
         3'd5: ldv = {16'd0, q_item.load_value[15:0]};
         default: ldv = q_item.load_value;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      lw_in = lw_ff;
      halt_in = halt_ff;
      ld_in = ld_ff;
      lf_in = lf_ff;
      ov_in = ov_ff && !out_ready;
      ob_in = ob_ff;
      rf_we = 1'b0;
      rf_wa = 5'd0;
      rf_wd = 32'd0;
      cap = 1'b0;
      if (csr_we) pc_in = csr_wdata;
      unique case (state_ff)
         S_RUN: if (go) begin
            ov_in = 1'b1;
            ob_in = '0;
            ob_in.next_pc = pc_ff;
            if (halt_ff) begin
               ob_in.status = ST_HALTED;
            end else if (q_item.cmd) begin
               if (!lw_ff) begin
                  ob_in.status = ST_SEQ;
               end else begin
                  lw_in = 1'b0;
                  if (ld_ff != 5'd0 && {27'd0, ld_ff} < REG_COUNT) begin
                     ob_in.dest_write = 1'b1;
                     ob_in.dest_reg = ld_ff;
                     ob_in.dest_value = ldv;
                     rf_we = 1'b1;
                     rf_wa = ld_ff;
                     rf_wd = ldv;
                  end
               end
            end else if (lw_ff) begin
               ob_in.status = ST_SEQ;
            end else if (w == EBREAK_WORD) begin
               halt_in = 1'b1;
               ob_in.status = ST_EBREAK;
               ob_in.status_value = ra10;
            end else if (r.status == ST_INVALID) begin
               halt_in = 1'b1;
               ob_in = r;
            end else if (is_mul || is_div) begin
               ov_in = 1'b0;
               cap = 1'b1;
               state_in = is_mul ? S_MUL : S_DIV;
            end else begin
               ob_in = r;
               pc_in = npc;
               if (opc == OP_LOAD) begin
                  lw_in = 1'b1;
                  ld_in = rd;
                  lf_in = f3;
               end
               if (r.dest_write) begin
                  rf_we = 1'b1;
                  rf_wa = rd;
                  rf_wd = val;
               end
            end
         end
         S_MUL, S_DIVWAIT: if (state_ff == S_MUL || ddone) begin
            ov_in = 1'b1;
            ob_in = '0;
            ob_in.next_pc = mpc_ff + 32'd4;
            pc_in = mpc_ff + 32'd4;
            state_in = S_RUN;
            if (mrd_ff != 5'd0 && {27'd0, mrd_ff} < REG_COUNT) begin
               ob_in.dest_write = 1'b1;
               ob_in.dest_reg = mrd_ff;
               ob_in.dest_value = xres;
               rf_we = 1'b1;
               rf_wa = mrd_ff;
               rf_wd = xres;
            end
         end
         S_DIV: state_in = S_DIVWAIT;
         default: state_in = S_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_RUN;
         pc_ff     <= RESET_VECTOR_DEFAULT;
         rf_vld_ff <= '0;
         lw_ff     <= 1'b0;
         halt_ff   <= 1'b0;
         ld_ff     <= 5'd0;
         lf_ff     <= 3'd0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         lw_ff    <= lw_in;
         halt_ff  <= halt_in;
         ld_ff    <= ld_in;
         lf_ff    <= lf_in;
         ov_ff    <= ov_in;
         if (rf_we) begin
            rf_vld_ff[rf_wa[REG_IDX_W-1:0]] <= 1'b1;
            rf_ff[rf_wa[REG_IDX_W-1:0]] <= rf_wd;
         end
      end
      ob_ff <= ob_in;
      if (cap) begin
         mf3_ff  <= f3;
         mrd_ff  <= rd;
         mpc_ff  <= pc_ff;
         prod_ff <= prod_in;
         na_ff   <= (f3[0] == 1'b0) && a[31];
         nb_ff   <= (f3[0] == 1'b0) && b[31];
         da_ff   <= ((f3[0] == 1'b0) && a[31]) ? 32'd0 - a : a;
         db_ff   <= ((f3[0] == 1'b0) && b[31]) ? 32'd0 - b : b;
      end
   end
endmodule

// ----- rtl/core/rv32im_execute_core.sv -----
// ----------------------------------------------------------------------------
// RV32IM execute core
// Executes a subset of the RV32IM instruction words and load returns, one result per item.
//
// Channel   Dir  Contents
// req_      in   tuser cmd; tdata instruction_word, load_value
// rsp_      out  tdata next_pc .. status_value
// csr_      in   pc write
//
// Most items pass through the queue and then the result register; mul and mulh
// also pass the operand capture registers. Div and rem use a one-bit-per-cycle divider.
// Reset clears the pc to 0x80000000 and marks all registers as zero at once.
// A two-entry queue lets the input accept up to two items while a result stalls.
// ----------------------------------------------------------------------------
`include "rv32im_execute_core_macros.svh"
module rv32im_execute_core import rvx_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [31:0]   csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // instruction_word, load_value
   input  logic          req_tuser,   // cmd
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [175:0]  rsp_tdata    // next_pc, mem_kind, mem_address,
                                      // mem_size_code, store_value, dest_write,
                                      // dest_reg, dest_value, status, status_value
);
   req_item_type in_item, q_item;
   rsp_item_type o;
   logic         q_valid, q_ready;

   assign in_item.cmd = req_tuser;
   assign in_item.word = req_tdata[31:0];
   assign in_item.load_value = req_tdata[63:32];

   rvx_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   rvx_back u_back (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_item(o)
   );

   assign rsp_tdata = {3'd0, o.status_value, o.status, o.dest_value, o.dest_reg,
      o.dest_write, o.store_value, o.mem_size_code, o.mem_address, o.mem_kind,
      o.next_pc};

   `RVX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped")
   `RVX_ASSERT_IMPL(a_x0_write, clock, reset, rsp_tvalid && o.dest_write, o.dest_reg != 5'd0, "x0 write")
   `RVX_ASSERT_IMPL(a_trap_mem, clock, reset, rsp_tvalid && o.status != ST_OK, o.mem_kind == MEM_NONE, "trap request")
endmodule
